/* hw/rtl/bmsd_pkg.sv */
// ---------------------------------------------------------------------------
// bmsd_pkg
// Types, codes and small helpers shared by the bank select RAM board.
// ---------------------------------------------------------------------------
package bmsd_pkg;

   localparam int LIVE_W    = 10;  // width of the bank live flags
   localparam int NCOUNT_W  = 4;   // width of a bank count
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   // Bus commands.
   localparam logic [2:0] CMD_MEM_READ  = 3'd0;
   localparam logic [2:0] CMD_MEM_WRITE = 3'd1;
   localparam logic [2:0] CMD_IO_WRITE  = 3'd2;
   localparam logic [2:0] CMD_BUS_RESET = 3'd3;

   // Decode styles.
   localparam logic [1:0] STYLE_ONEHOT = 2'd0;
   localparam logic [1:0] STYLE_MASK   = 2'd1;
   localparam logic [1:0] STYLE_TOGGLE = 2'd2;
   localparam logic [1:0] STYLE_PAGE   = 2'd3;

   // Common region settings.
   localparam logic [1:0] PART_NONE = 2'd0;
   localparam logic [1:0] PART_16K  = 2'd1;
   localparam logic [1:0] PART_32K  = 2'd2;

   // Phantom handling.
   localparam logic [1:0] PHANTOM_IGNORE     = 2'd0;
   localparam logic [1:0] PHANTOM_DROP_READS = 2'd1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CARD_TYPE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_PORT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BANK_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PARTITION     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PHANTOM_HONOR = 3'd4;

   localparam logic [7:0]  ONEHOT_KEEP    = 8'hBF;
   localparam logic [7:0]  TOGGLE_KEEP    = 8'hFE;
   localparam logic [7:0]  TOGGLE_OFF     = 8'h01;
   localparam logic [15:0] COMMON_BASE_16K = 16'hC000;
   localparam logic [15:0] COMMON_BASE_32K = 16'h8000;
   localparam logic [7:0]  IDLE_DATA      = 8'hFF;
   localparam logic [7:0]  SELECT_PORT_RST = 8'h40;
   localparam logic [NCOUNT_W-1:0] BANK_COUNT_RST = 4'd1;
   localparam logic [LIVE_W-1:0]   LIVE_RST = 10'd1;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        phantom;
   } req_type;

   typedef struct packed {
      logic                responds;
      logic [7:0]          read_data;
      logic                bus_fight;
      logic                select_rejected;
      logic [LIVE_W-1:0]   active_mask;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          card_type;
      logic [7:0]          select_port;
      logic [NCOUNT_W-1:0] bank_count;
      logic [1:0]          partition;
      logic [1:0]          phantom_honor;
   } cfg_type;

   typedef struct packed {
      logic              rejected;
      logic [LIVE_W-1:0] live_next;
   } sel_type;

   // Bank count clipped to the range that the decode style can address.
   function automatic logic [NCOUNT_W-1:0] style_count(input logic [1:0] style,
                                                       input logic [NCOUNT_W-1:0] count);
      logic [NCOUNT_W-1:0] cap;
      logic [NCOUNT_W-1:0] n;
      unique case (style)
         STYLE_ONEHOT: cap = 4'd8;
         STYLE_MASK:   cap = 4'd8;
         STYLE_TOGGLE: cap = 4'd6;
         default:      cap = 4'd10;
      endcase
      n = (count == '0) ? 4'd1 : count;
      if (n > cap) begin
         n = cap;
      end
      return n;
   endfunction

   // Bit i set for every bank index below n.
   function automatic logic [LIVE_W-1:0] low_mask(input logic [NCOUNT_W-1:0] n);
      logic [LIVE_W-1:0] m;
      for (int i = 0; i < LIVE_W; i++) begin
         m[i] = (NCOUNT_W'(i) < n);
      end
      return m;
   endfunction

   function automatic logic [LIVE_W-1:0] bank_bit(input logic [NCOUNT_W-1:0] idx);
      return LIVE_W'(1) << idx;
   endfunction

endpackage

/* hw/rtl/banked_memory_select_decode_top.sv */
// ---------------------------------------------------------------------------
// banked_memory_select_decode_top
// Bank switched RAM board: select port decode, owner search and bank RAM.
// ---------------------------------------------------------------------------
// Each request beat is one bus cycle: memory read, memory write, I/O write or
// bus reset. Every request beat yields exactly one response beat, in order.
// The live flags sit in flip-flops; the owner of a memory address is found
// in the accept cycle and the bank RAM or the common RAM is read or written
// at that same edge. The RAM read data is ready right after that edge and is
// registered into the output stage once that stage can take it. A new request
// is taken every cycle while req_stall is low; the single port of each RAM,
// used once per beat, sets that rate.
// When the response side stalls, one beat waits in the output register and a
// second in the stage behind it; only then does req_stall rise.
// Reset clears the registers to their defaults with only bank 0 live and
// empties both stages. The RAM contents are not cleared and no clearing pass
// runs. A write to a used register index also makes only bank 0 live again.
// The user must write registers only while no beat is in flight (unchecked).
// ---------------------------------------------------------------------------
module banked_memory_select_decode_top #(
   parameter int MAX_BANKS    = 10,
   parameter int BANK_BYTES   = 65536,   // power of two
   parameter int COMMON_BYTES = 32768    // power of two
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bmsd_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bmsd_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [bmsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmsd_pkg::CSR_DAT_W-1:0]     csr_write_data
);
   import bmsd_pkg::*;

   localparam int BANK_DEPTH = MAX_BANKS * BANK_BYTES;
   localparam int BANK_RAM_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int BANK_OFF_W = $clog2(BANK_BYTES);
   localparam int COM_AW = $clog2(COMMON_BYTES);
   localparam logic [NCOUNT_W-1:0] MAX_N =
      NCOUNT_W'((MAX_BANKS > LIVE_W) ? LIVE_W : MAX_BANKS);

   cfg_type             cfg_ff, cfg_in;
   logic [LIVE_W-1:0]   live_ff, live_in;

   logic                s1_valid_ff, s1_valid_in;
   rsp_type             s1_rsp_ff;
   logic                s1_read_ff;
   logic                s1_common_ff;
   rsp_type             s1_out;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic                s1_move;
   logic                cfg_hit;

   logic [NCOUNT_W-1:0] bank_n;
   sel_type             sel;
   logic                is_mem;
   logic                is_read;
   logic                drop;
   logic                in_common;
   logic [LIVE_W-1:0]   owners;
   logic [NCOUNT_W-1:0] first_bank;
   logic                hit;
   logic                fight;
   logic                mem_go;
   rsp_type             rsp_now;
   logic [LIVE_W-1:0]   live_next;

   logic [BANK_RAM_AW-1:0] bank_addr;
   logic [COM_AW-1:0]      com_base_lo;
   logic [COM_AW-1:0]      com_addr;
   logic [7:0]             bank_rdata;
   logic [7:0]             com_rdata;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   // ---- configuration ----
   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b0;
      if (csr_write_en) begin
         cfg_hit = 1'b1;
         unique case (csr_index)
            REG_CARD_TYPE:     cfg_in.card_type     = csr_write_data[1:0];
            REG_SELECT_PORT:   cfg_in.select_port   = csr_write_data;
            REG_BANK_COUNT:    cfg_in.bank_count    = csr_write_data[NCOUNT_W-1:0];
            REG_PARTITION:     cfg_in.partition     = csr_write_data[1:0];
            REG_PHANTOM_HONOR: cfg_in.phantom_honor = csr_write_data[1:0];
            default:           cfg_hit = 1'b0;
         endcase
      end
   end

   // ---- owner search ----
   always_comb begin
      bank_n = style_count(cfg_ff.card_type, cfg_ff.bank_count);
      if (bank_n > MAX_N) begin
         bank_n = MAX_N;
      end
   end

   assign is_mem  = (req_data.command == CMD_MEM_READ) ||
                    (req_data.command == CMD_MEM_WRITE);
   assign is_read = (req_data.command == CMD_MEM_READ);
   assign drop    = req_data.phantom && (cfg_ff.phantom_honor != PHANTOM_IGNORE) &&
                    ((cfg_ff.phantom_honor != PHANTOM_DROP_READS) || is_read);

   always_comb begin
      in_common = 1'b0;
      if (cfg_ff.card_type == STYLE_PAGE) begin
         if (cfg_ff.partition == PART_16K) begin
            in_common = (req_data.address >= COMMON_BASE_16K);
         end else if (cfg_ff.partition == PART_32K) begin
            in_common = (req_data.address >= COMMON_BASE_32K);
         end
      end
   end

   // The common region and the banked window never overlap, so a fight is
   // only ever between banks.
   always_comb begin
      owners     = in_common ? '0 : (live_ff & low_mask(bank_n));
      first_bank = '0;
      for (int i = LIVE_W - 1; i >= 0; i--) begin
         if (owners[i]) begin
            first_bank = NCOUNT_W'(i);
         end
      end
      hit   = (owners != '0) || in_common;
      fight = (owners & (owners - LIVE_W'(1))) != '0;
   end

   assign mem_go = accept && is_mem && !drop && hit;

   assign bank_addr   = BANK_RAM_AW'({first_bank, req_data.address[BANK_OFF_W-1:0]});
   assign com_base_lo = (cfg_ff.partition == PART_16K) ? COMMON_BASE_16K[COM_AW-1:0] :
                                                         COMMON_BASE_32K[COM_AW-1:0];
   assign com_addr    = req_data.address[COM_AW-1:0] - com_base_lo;

   // ---- select decode ----
   bmsd_select u_select (
      .card_type (cfg_ff.card_type),
      .bank_n    (bank_n),
      .sel_byte  (req_data.write_data),
      .live      (live_ff),
      .sel       (sel)
   );

   always_comb begin
      rsp_now   = '0;
      rsp_now.read_data = IDLE_DATA;
      live_next = live_ff;
      unique case (req_data.command)
         CMD_MEM_READ, CMD_MEM_WRITE: begin
            if (!drop && hit) begin
               rsp_now.responds  = 1'b1;
               rsp_now.bus_fight = fight;
            end
         end
         CMD_IO_WRITE: begin
            if (req_data.address[7:0] == cfg_ff.select_port) begin
               rsp_now.responds        = 1'b1;
               rsp_now.select_rejected = sel.rejected;
               live_next               = sel.live_next;
            end
         end
         CMD_BUS_RESET: begin
            live_next = LIVE_RST;
         end
         default: begin
            live_next = live_ff;
         end
      endcase
      rsp_now.active_mask = live_next;
   end

   always_comb begin
      live_in = live_ff;
      if (cfg_hit) begin
         live_in = LIVE_RST;
      end else if (accept) begin
         live_in = live_next;
      end
   end

   // ---- storage ----
   bmsd_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_bank_ram (
      .clock (clock),
      .en    (mem_go && !in_common),
      .we    (!is_read),
      .addr  (bank_addr),
      .wdata (req_data.write_data),
      .rdata (bank_rdata)
   );

   bmsd_ram #(
      .WIDTH (8),
      .DEPTH (COMMON_BYTES)
   ) u_common_ram (
      .clock (clock),
      .en    (mem_go && in_common),
      .we    (!is_read),
      .addr  (com_addr),
      .wdata (req_data.write_data),
      .rdata (com_rdata)
   );

   // ---- response stages ----
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // The RAM read data joins the waiting beat on its way to the output.
   always_comb begin
      s1_out = s1_rsp_ff;
      if (s1_read_ff) begin
         s1_out.read_data = s1_common_ff ? com_rdata : bank_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.card_type     <= STYLE_ONEHOT;
         cfg_ff.select_port   <= SELECT_PORT_RST;
         cfg_ff.bank_count    <= BANK_COUNT_RST;
         cfg_ff.partition     <= PART_NONE;
         cfg_ff.phantom_honor <= PHANTOM_IGNORE;
         live_ff              <= LIVE_RST;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         live_ff      <= live_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff    <= rsp_now;
         s1_read_ff   <= mem_go && is_read;
         s1_common_ff <= in_common;
      end
      if (s1_move) begin
         rsp_data_ff <= s1_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/bmsd_ram.sv */
// ---------------------------------------------------------------------------
// bmsd_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module bmsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // The read data holds until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bmsd_select.sv */
// ---------------------------------------------------------------------------
// bmsd_select
// Decodes a select port byte into the next bank live flags.
// ---------------------------------------------------------------------------
module bmsd_select (
   input  logic [1:0]                          card_type,
   input  logic [bmsd_pkg::NCOUNT_W-1:0]       bank_n,
   input  logic [7:0]                          sel_byte,
   input  logic [bmsd_pkg::LIVE_W-1:0]         live,
   output bmsd_pkg::sel_type                   sel
);
   import bmsd_pkg::*;

   logic [7:0]          oh_bits;
   logic [2:0]          oh_pos;
   logic                oh_ok;
   logic [7:0]          tg_bits;
   logic [2:0]          tg_pos;
   logic [NCOUNT_W-1:0] tg_bank;
   logic                tg_ok;

   always_comb begin
      oh_bits = sel_byte & ONEHOT_KEEP;
      oh_pos  = '0;
      for (int i = 0; i < 8; i++) begin
         if (oh_bits[i]) begin
            oh_pos = 3'(i);
         end
      end
      oh_ok = $onehot(oh_bits) && ({1'b0, oh_pos} < bank_n);
   end

   // Bits 7..1 name bank b-1; bit 0 chooses on (low) or off (high).
   always_comb begin
      tg_bits = sel_byte & TOGGLE_KEEP;
      tg_pos  = '0;
      for (int i = 1; i < 8; i++) begin
         if (tg_bits[i]) begin
            tg_pos = 3'(i);
         end
      end
      tg_bank = {1'b0, tg_pos} - NCOUNT_W'(1);
      tg_ok   = $onehot(tg_bits) && (tg_bank < bank_n);
   end

   always_comb begin
      sel.rejected  = 1'b0;
      sel.live_next = live;
      unique case (card_type)
         STYLE_ONEHOT: begin
            if (oh_ok) begin
               sel.live_next = bank_bit({1'b0, oh_pos});
            end else begin
               sel.rejected = 1'b1;
            end
         end
         STYLE_MASK: begin
            sel.live_next = {{(LIVE_W-8){1'b0}}, sel_byte} & low_mask(bank_n);
         end
         STYLE_TOGGLE: begin
            if (!tg_ok) begin
               sel.rejected = 1'b1;
            end else if ((sel_byte & TOGGLE_OFF) == '0) begin
               sel.live_next = live | bank_bit(tg_bank);
            end else begin
               sel.live_next = live & ~bank_bit(tg_bank);
            end
         end
         default: begin
            if (sel_byte < {4'b0, bank_n}) begin
               sel.live_next = bank_bit(sel_byte[NCOUNT_W-1:0]);
            end else begin
               sel.rejected = 1'b1;
            end
         end
      endcase
   end

endmodule

/* hw/rtl/bmsd_checker.sv */
// ---------------------------------------------------------------------------
// bmsd_checker
// Port level checks for the bank select RAM board, bound to the top level.
// ---------------------------------------------------------------------------
module bmsd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  bmsd_pkg::rsp_type                  rsp_data
);
   import bmsd_pkg::*;

   // No response beat can be offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Rejects come only from select port writes, fights only from memory cycles.
   a_flag_responds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.bus_fight || rsp_data.select_rejected) |-> rsp_data.responds)
      else $error("flag set on a cycle the board did not answer");

   a_flag_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.bus_fight && rsp_data.select_rejected))
      else $error("bus fight and select reject on the same beat");

   // A fight needs at least two live banks.
   a_fight_banks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_fight |-> !$onehot0(rsp_data.active_mask))
      else $error("bus fight with fewer than two live banks");

endmodule

bind banked_memory_select_decode_top bmsd_checker u_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bank select RAM board. A short table of bus
// cycles and register writes runs first; a few rows carry a typed-in answer.
// Random phases follow, each under its own register setting, in three pacings.
// Every response beat is compared field by field against its typed-in answer
// or an in-bench model of the live flags, select decode, bank and common RAM.
// ---------------------------------------------------------------------------
module tb_top;
   import bmsd_pkg::*;

   localparam int PHASES         = 12;
   localparam int PHASE_BEATS    = 153;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRINT_LIMIT    = 40;
   localparam int BANK_SPAN      = 65536;
   localparam int REGION_SPAN    = 32768;
   localparam int REGION_KEY     = 10;     // owner slot of the common region

   localparam logic [2:0] CMD_OTHER_LO      = 3'd4;
   localparam logic [2:0] CMD_OTHER_HI      = 3'd7;
   localparam logic [1:0] PART_RESERVED     = 2'd3;
   localparam logic [1:0] PHANTOM_DROP_ALL  = 2'd2;
   localparam logic [1:0] PHANTOM_RESERVED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      req_type              beat;
      bit                   typed;
      rsp_type              want;
      logic [CSR_IDX_W-1:0] idx;
      logic [7:0]           val;
   } plan_row_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   req_type               req_data       = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DAT_W-1:0]  csr_write_data = '0;

   // Board model state.
   cfg_type           cfg_now;
   logic [LIVE_W-1:0] live_now;
   logic [7:0]        board_ram [int];   // only cells that were written exist

   rsp_type      rsp_expect [$];
   plan_row_type plan [$];
   int      send_idle_pct = 13;
   int      rsp_idle_pct  = 71;
   int      beats_sent    = 0;
   int      beats_checked = 0;
   int      settings_done = 0;
   int      mismatches    = 0;

   logic [15:0] hot_addr [16] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h7FFF,
                                 16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001,
                                 16'h3FFF, 16'h4000, 16'h1234, 16'hABCD, 16'h5555,
                                 16'hAAAA};

   cfg_type extreme_cards [5] = '{
      '{STYLE_ONEHOT, 8'h00, 4'd0,  PART_32K,      PHANTOM_RESERVED},
      '{STYLE_MASK,   8'hFF, 4'd15, PART_RESERVED, PHANTOM_IGNORE},
      '{STYLE_TOGGLE, 8'h40, 4'd15, PART_16K,      PHANTOM_DROP_READS},
      '{STYLE_PAGE,   8'h80, 4'd10, PART_32K,      PHANTOM_DROP_ALL},
      '{STYLE_PAGE,   8'h01, 4'd1,  PART_16K,      PHANTOM_IGNORE}
   };

   banked_memory_select_decode_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Board model
   // ------------------------------------------------------------------
   function automatic int unsigned fitted_banks();
      int unsigned cap;
      int unsigned n;
      case (cfg_now.card_type)
         STYLE_ONEHOT, STYLE_MASK: cap = 8;
         STYLE_TOGGLE:             cap = 6;
         default:                  cap = 10;
      endcase
      n = cfg_now.bank_count;
      if (n < 1) n = 1;
      if (n > cap) n = cap;
      return n;
   endfunction

   // Zero means that no common region is fitted.
   function automatic logic [15:0] region_base();
      if (cfg_now.card_type != STYLE_PAGE) return 16'h0000;
      if (cfg_now.partition == PART_16K) return COMMON_BASE_16K;
      if (cfg_now.partition == PART_32K) return COMMON_BASE_32K;
      return 16'h0000;
   endfunction

   // Key of the RAM cell that answers the address, or -1 with no owner.
   function automatic int owner_key(input logic [15:0] addr, output int hits);
      int unsigned n;
      logic [15:0] base;
      int key;
      int i;
      n = fitted_banks();
      base = region_base();
      key = -1;
      hits = 0;
      if (base == 16'h0000 || addr < base) begin
         for (i = 0; i < int'(n); i++) begin
            if (live_now[i]) begin
               if (key < 0) key = i * BANK_SPAN + int'(addr);
               hits++;
            end
         end
      end
      if (base != 16'h0000 && addr >= base) begin
         if (key < 0) key = REGION_KEY * BANK_SPAN + ((int'(addr) - int'(base)) % REGION_SPAN);
         hits++;
      end
      return key;
   endfunction

   function automatic bit phantom_drops(input req_type r);
      return r.phantom && (cfg_now.phantom_honor >= PHANTOM_DROP_ALL ||
                           (cfg_now.phantom_honor == PHANTOM_DROP_READS &&
                            r.command == CMD_MEM_READ));
   endfunction

   // Applies a select byte to the live flags; returns 1 when it is refused.
   function automatic bit apply_select(input logic [7:0] d);
      int unsigned n;
      logic [7:0] h;
      int pos;
      int i;
      n = fitted_banks();
      pos = -1;
      case (cfg_now.card_type)
         STYLE_ONEHOT: begin
            h = d & ONEHOT_KEEP;
            for (i = 0; i < 8; i++) if (h == 8'(1 << i)) pos = i;
            if (pos < 0 || pos >= int'(n)) return 1'b1;
            live_now = LIVE_W'(1) << pos;
         end
         STYLE_MASK: begin
            live_now = '0;
            for (i = 0; i < int'(n) && i < 8; i++) live_now[i] = d[i];
         end
         STYLE_TOGGLE: begin
            h = d & TOGGLE_KEEP;
            for (i = 1; i <= 7; i++) if (h == 8'(1 << i)) pos = i;
            if (pos < 0 || pos - 1 >= int'(n)) return 1'b1;
            live_now[pos-1] = ((d & TOGGLE_OFF) == 8'h00);
         end
         default: begin
            if (int'(d) >= int'(n)) return 1'b1;
            live_now = LIVE_W'(1) << d;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic rsp_type model_beat(input req_type r);
      rsp_type e;
      int key;
      int hits;
      e = '0;
      e.read_data = IDLE_DATA;
      case (r.command)
         CMD_MEM_READ, CMD_MEM_WRITE: begin
            if (!phantom_drops(r)) begin
               key = owner_key(r.address, hits);
               if (key >= 0) begin
                  e.responds = 1'b1;
                  e.bus_fight = (hits > 1);
                  if (r.command == CMD_MEM_READ) e.read_data = board_ram[key];
                  else board_ram[key] = r.write_data;
               end
            end
         end
         CMD_IO_WRITE: begin
            if (r.address[7:0] == cfg_now.select_port) begin
               e.responds = 1'b1;
               e.select_rejected = apply_select(r.write_data);
            end
         end
         CMD_BUS_RESET: live_now = LIVE_RST;
         default: ;
      endcase
      e.active_mask = live_now;
      return e;
   endfunction

   // A read that would reach a never written cell becomes a write instead.
   function automatic req_type make_safe(input req_type r);
      int key;
      int hits;
      if (r.command == CMD_MEM_READ && !phantom_drops(r)) begin
         key = owner_key(r.address, hits);
         if (key >= 0 && !board_ram.exists(key)) r.command = CMD_MEM_WRITE;
      end
      return r;
   endfunction

   // Mostly well-formed select bytes and reused addresses, some noise.
   function automatic req_type random_beat();
      req_type r;
      int unsigned n;
      int unsigned roll;
      n = fitted_banks();
      roll = $urandom_range(99);
      r.address = 16'($urandom);
      r.write_data = 8'($urandom);
      r.phantom = ($urandom_range(99) < 15);
      if (roll < 22) begin
         r.command = CMD_IO_WRITE;
         if ($urandom_range(99) < 85) r.address[7:0] = cfg_now.select_port;
         if ($urandom_range(99) < 75) begin
            case (cfg_now.card_type)
               STYLE_ONEHOT: begin
                  r.write_data = 8'(1 << $urandom_range(n - 1));
                  r.write_data[6] = 1'($urandom);
               end
               STYLE_MASK: ;
               STYLE_TOGGLE: r.write_data = 8'(1 << $urandom_range(7, 1)) |
                                            8'($urandom_range(1));
               default: r.write_data = ($urandom_range(3) == 0) ? 8'($urandom_range(15))
                                                                 : 8'($urandom_range(n - 1));
            endcase
         end
      end else if (roll < 25) begin
         r.command = CMD_BUS_RESET;
      end else if (roll < 28) begin
         r.command = 3'($urandom_range(CMD_OTHER_HI, CMD_OTHER_LO));
      end else begin
         r.command = ($urandom_range(99) < 55) ? CMD_MEM_READ : CMD_MEM_WRITE;
         if ($urandom_range(99) < 60) r.address = hot_addr[$urandom_range(15)];
      end
      return r;
   endfunction

   function automatic void add_expect(input rsp_type e);
      rsp_expect = {rsp_expect, e};
   endfunction

   function automatic void add_row(input plan_row_type row);
      plan = {plan, row};
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_beat(input req_type r, input bit typed, input rsp_type want);
      rsp_type e;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = model_beat(r);
      add_expect(typed ? want : e);
      beats_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Writes one register once the board has gone quiet.
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      while (rsp_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_done++;
      case (idx)
         REG_CARD_TYPE:     cfg_now.card_type     = val[1:0];
         REG_SELECT_PORT:   cfg_now.select_port   = val;
         REG_BANK_COUNT:    cfg_now.bank_count    = val[NCOUNT_W-1:0];
         REG_PARTITION:     cfg_now.partition     = val[1:0];
         REG_PHANTOM_HONOR: cfg_now.phantom_honor = val[1:0];
         default: return;
      endcase
      live_now = LIVE_RST;
   endtask

   function automatic plan_row_type row_beat(input logic [2:0] cmd, input logic [15:0] addr,
                                             input logic [7:0] data, input logic ph);
      plan_row_type row;
      row.kind  = ROW_BEAT;
      row.beat  = '{cmd, addr, data, ph};
      row.typed = 1'b0;
      row.want  = '0;
      row.idx   = '0;
      row.val   = '0;
      return row;
   endfunction

   // Rows whose answer is plain to see; none of them touches a bus fight.
   function automatic plan_row_type row_typed(input logic [2:0] cmd, input logic [15:0] addr,
                                              input logic [7:0] data, input logic ph,
                                              input logic resp, input logic [7:0] rd,
                                              input logic rej);
      plan_row_type row;
      row = row_beat(cmd, addr, data, ph);
      row.typed = 1'b1;
      row.want.responds = resp;
      row.want.read_data = rd;
      row.want.select_rejected = rej;
      row.want.active_mask = LIVE_RST;
      return row;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [7:0] val);
      plan_row_type row;
      row = row_beat(CMD_MEM_READ, 16'h0000, 8'h00, 1'b0);
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.val  = val;
      return row;
   endfunction

   // ------------------------------------------------------------------
   // Response side: checks each beat and paces rsp_stall, with one long
   // hold-off so that both stages fill and the request side stalls.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("response %0d: %s is %h, model has %h", beats_checked, field, got, want);
   endtask

   initial begin : response_side
      rsp_type seen;
      rsp_type want;
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen = rsp_data;
            if (rsp_expect.size() == 0) begin
               report_mismatch("beat with nothing pending, active_mask", 16'(seen.active_mask),
                               16'h0000);
            end else begin
               want = rsp_expect.pop_front();
               if (seen.responds !== want.responds)
                  report_mismatch("responds", 16'(seen.responds), 16'(want.responds));
               if (seen.read_data !== want.read_data)
                  report_mismatch("read_data", 16'(seen.read_data), 16'(want.read_data));
               if (seen.bus_fight !== want.bus_fight)
                  report_mismatch("bus_fight", 16'(seen.bus_fight), 16'(want.bus_fight));
               if (seen.select_rejected !== want.select_rejected)
                  report_mismatch("select_rejected", 16'(seen.select_rejected),
                                  16'(want.select_rejected));
               if (seen.active_mask !== want.active_mask)
                  report_mismatch("active_mask", 16'(seen.active_mask), 16'(want.active_mask));
            end
            beats_checked++;
         end
         if (!held && beats_checked >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("no beat accepted for %0d cycles, %0d responses outstanding", quiet,
               rsp_expect.size());
      $display("tb_top failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      cfg_type c;
      int p;
      int i;

      cfg_now = '{STYLE_ONEHOT, SELECT_PORT_RST, BANK_COUNT_RST, PART_NONE, PHANTOM_IGNORE};
      live_now = LIVE_RST;

      add_row(row_typed(CMD_OTHER_LO, 16'h0000, 8'h00, 1'b0, 1'b0, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_OTHER_HI, 16'hFFFF, 8'hFF, 1'b1, 1'b0, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_MEM_WRITE, 16'h0000, 8'h00, 1'b0, 1'b1, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_MEM_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b1, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_MEM_READ, 16'h0000, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0));
      // Bit 6 of a one-hot select byte is a don't-care.
      add_row(row_beat(CMD_IO_WRITE, 16'h0040, 8'h41, 1'b0));
      add_row(row_typed(CMD_IO_WRITE, 16'h0040, 8'h02, 1'b0, 1'b1, IDLE_DATA, 1'b1));
      add_row(row_typed(CMD_IO_WRITE, 16'h0041, 8'h01, 1'b0, 1'b0, IDLE_DATA, 1'b0));
      // Page style with the count clipped, bank 9 live and a 16K common top.
      add_row(row_csr(REG_CARD_TYPE, 8'(STYLE_PAGE)));
      add_row(row_csr(REG_BANK_COUNT, 8'd15));
      add_row(row_csr(REG_PARTITION, 8'(PART_16K)));
      add_row(row_beat(CMD_IO_WRITE, 16'hFF40, 8'h09, 1'b0));
      add_row(row_beat(CMD_MEM_WRITE, 16'hC000, 8'h3C, 1'b1));
      add_row(row_beat(CMD_MEM_READ, 16'hC000, 8'h00, 1'b0));
      add_row(row_beat(CMD_MEM_WRITE, 16'h7FFF, 8'h11, 1'b0));
      add_row(row_beat(CMD_MEM_READ, 16'h7FFF, 8'h00, 1'b0));
      // Reserved partition means no common top; reserved honor drops every phantom.
      add_row(row_csr(REG_PARTITION, 8'(PART_RESERVED)));
      add_row(row_csr(REG_PHANTOM_HONOR, 8'(PHANTOM_RESERVED)));
      add_row(row_typed(CMD_MEM_READ, 16'h0000, 8'h00, 1'b1, 1'b0, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_MEM_WRITE, 16'h0000, 8'h77, 1'b1, 1'b0, IDLE_DATA, 1'b0));
      add_row(row_typed(CMD_BUS_RESET, 16'h1234, 8'h00, 1'b0, 1'b0, IDLE_DATA, 1'b0));
      add_row(row_csr(REG_UNUSED_HI, 8'hFF));
      add_row(row_beat(CMD_MEM_READ, 16'h0000, 8'h00, 1'b0));
      add_row(row_beat(CMD_IO_WRITE, 16'h0040, 8'h00, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            set_reg(plan[i].idx, plan[i].val);
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         case (p * 3 / PHASES)
            0: begin send_idle_pct = 13; rsp_idle_pct = 71; end
            1: begin send_idle_pct = 71; rsp_idle_pct = 13; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (p < 5) begin
            c = extreme_cards[p];
         end else begin
            c.card_type     = 2'($urandom);
            c.select_port   = ($urandom_range(3) == 0) ? SELECT_PORT_RST : 8'($urandom);
            c.bank_count    = 4'($urandom);
            c.partition     = 2'($urandom);
            c.phantom_honor = 2'($urandom);
         end
         // Unused upper data bits are filled at random; the board keeps the low ones.
         req_valid <= 1'b0;
         set_reg(REG_CARD_TYPE, {6'($urandom), c.card_type});
         set_reg(REG_SELECT_PORT, c.select_port);
         set_reg(REG_BANK_COUNT, {4'($urandom), c.bank_count});
         set_reg(REG_PARTITION, {6'($urandom), c.partition});
         if ($urandom_range(3) == 0)
            set_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), 8'($urandom));
         set_reg(REG_PHANTOM_HONOR, {6'($urandom), c.phantom_honor});
         repeat (PHASE_BEATS) send_beat(make_safe(random_beat()), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (rsp_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request beats sent, %0d responses checked, %0d register writes",
               beats_sent, beats_checked, settings_done);
      $display("all decode styles, phantom modes and common regions under three pacings");
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/bmsd_pkg.sv
hw/rtl/bmsd_ram.sv
hw/rtl/bmsd_select.sv
hw/rtl/banked_memory_select_decode_top.sv
hw/rtl/bmsd_checker.sv
tb/sv/tb_top.sv
